// ===== design/qalu_pkg.sv =====
package qalu_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_MUL  = 2'd0;
  localparam func_t FUNC_ROT  = 2'd1;
  localparam func_t FUNC_CONJ = 2'd2;
  localparam func_t FUNC_NORM = 2'd3;

  localparam int NUM_COMP = 4;
  localparam int ARITH_LAT = 8;

endpackage

// ===== design/qalu_arith.sv =====
module qalu_arith #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  qalu_pkg::func_t     func_i,
  input  logic signed [W-1:0] a_i [qalu_pkg::NUM_COMP],
  input  logic signed [W-1:0] b_i [qalu_pkg::NUM_COMP],
  output qalu_pkg::func_t     func_o,
  output logic signed [W-1:0] r_o [qalu_pkg::NUM_COMP],
  output logic                sat_o
);

  localparam int PW  = 2 * W;
  localparam int TW  = PW + 2;
  localparam int TRW = TW - F;
  localparam int CW  = PW + 1;
  localparam int UW  = CW - F;
  localparam int LW  = UW / 2;
  localparam int HW  = UW - LW;
  localparam int MW  = W + UW;
  localparam int XW  = MW + 2;
  localparam int YW  = XW + 2 - F;
  localparam int ZW  = YW + 1;
  localparam int SW0 = (ZW > TRW) ? ZW : TRW;
  localparam int SW  = (SW0 > W + 1) ? SW0 : W + 1;

  localparam logic signed [TW-1:0]   HALF_T = TW'(2 ** (F - 1));
  localparam logic signed [CW-1:0]   HALF_C = CW'(2 ** (F - 1));
  localparam logic signed [XW+1:0]   HALF_X = (XW + 2)'(2 ** (F - 1));

  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
    logic [SW-W:0] hi;
    hi = v[SW-1:W-1];
    if ((&hi) || !(|hi)) begin
      sat_fn = {1'b0, v[W-1:0]};
    end else begin
      sat_fn = {1'b1, v[SW-1], {(W-1){~v[SW-1]}}};
    end
  endfunction

  qalu_pkg::func_t f1_q, f2_q, f3_q, f4_q, f5_q, f6_q, f7_q, f8_q;

  logic signed [W-1:0]    a1_q [4];
  logic signed [W-1:0]    a2_q [4];
  logic signed [W-1:0]    a3_q [4];
  logic signed [W-1:0]    bv1_q [3];
  logic signed [W-1:0]    bv2_q [3];
  logic signed [W-1:0]    bv3_q [3];
  logic signed [W-1:0]    bv4_q [3];
  logic signed [W-1:0]    bv5_q [3];
  logic signed [W-1:0]    bv6_q [3];
  logic signed [W-1:0]    bv7_q [3];

  logic signed [PW-1:0]   p1_d [4][4];
  logic signed [PW-1:0]   p1_q [4][4];
  logic signed [TW-1:0]   t2_d [4];
  logic signed [TW-1:0]   t2_q [4];
  logic signed [CW-1:0]   c2_d [3];
  logic signed [CW-1:0]   c2_q [3];
  logic signed [TW-1:0]   tsum [4];
  logic signed [CW-1:0]   csum [3];
  logic signed [TRW-1:0]  t3_d [4];
  logic signed [TRW-1:0]  t3_q [4];
  logic signed [UW-1:0]   uv3_d [3];
  logic signed [UW-1:0]   uv3_q [3];

  logic [W:0]             msat [4];
  logic [W:0]             csat [4];
  logic signed [W:0]      aneg [4];
  logic signed [W-1:0]    res4_d [4];
  logic                   rs4_d;
  logic signed [W-1:0]    res4_q [4];
  logic signed [W-1:0]    res5_q [4];
  logic signed [W-1:0]    res6_q [4];
  logic signed [W-1:0]    res7_q [4];
  logic                   rs4_q, rs5_q, rs6_q, rs7_q;

  logic signed [W-1:0]    ma [9];
  logic signed [UW-1:0]   mu [9];
  logic signed [W+HW-1:0] hi4_d [9];
  logic signed [W+HW-1:0] hi4_q [9];
  logic signed [W+LW:0]   lo4_d [9];
  logic signed [W+LW:0]   lo4_q [9];
  logic signed [MW-1:0]   m5_d [9];
  logic signed [MW-1:0]   m5_q [9];
  logic signed [XW-1:0]   x6_d [3];
  logic signed [XW-1:0]   x6_q [3];
  logic signed [XW+1:0]   xdbl [3];
  logic signed [YW-1:0]   y7_d [3];
  logic signed [YW-1:0]   y7_q [3];
  logic signed [ZW-1:0]   z8 [3];
  logic [W:0]             zsat [3];
  logic signed [W-1:0]    r8_d [4];
  logic                   s8_d;
  logic signed [W-1:0]    r8_q [4];
  logic                   s8_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_d[i][j] = PW'(a_i[i]) * PW'(b_i[j]);
      end
    end
  end

  always_comb begin
    t2_d[0] = TW'(p1_q[0][0]) - TW'(p1_q[1][1]) - TW'(p1_q[2][2]) - TW'(p1_q[3][3]);
    t2_d[1] = TW'(p1_q[0][1]) + TW'(p1_q[1][0]) + TW'(p1_q[2][3]) - TW'(p1_q[3][2]);
    t2_d[2] = TW'(p1_q[0][2]) - TW'(p1_q[1][3]) + TW'(p1_q[2][0]) + TW'(p1_q[3][1]);
    t2_d[3] = TW'(p1_q[0][3]) + TW'(p1_q[1][2]) - TW'(p1_q[2][1]) + TW'(p1_q[3][0]);
    c2_d[0] = CW'(p1_q[2][3]) - CW'(p1_q[3][2]);
    c2_d[1] = CW'(p1_q[3][1]) - CW'(p1_q[1][3]);
    c2_d[2] = CW'(p1_q[1][2]) - CW'(p1_q[2][1]);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tsum[k] = t2_q[k] + HALF_T;
      t3_d[k] = tsum[k][TW-1:F];
    end
    for (int k = 0; k < 3; k++) begin
      csum[k]  = c2_q[k] + HALF_C;
      uv3_d[k] = csum[k][CW-1:F];
    end
  end

  always_comb begin
    rs4_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      msat[k] = sat_fn(SW'(t3_q[k]));
      aneg[k] = -((W + 1)'(a3_q[k]));
      csat[k] = sat_fn(SW'(aneg[k]));
    end
    case (f3_q)
      qalu_pkg::FUNC_MUL: begin
        for (int k = 0; k < 4; k++) begin
          res4_d[k] = msat[k][W-1:0];
          rs4_d     = rs4_d | msat[k][W];
        end
      end
      qalu_pkg::FUNC_CONJ: begin
        res4_d[0] = a3_q[0];
        for (int k = 1; k < 4; k++) begin
          res4_d[k] = csat[k][W-1:0];
          rs4_d     = rs4_d | csat[k][W];
        end
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          res4_d[k] = '0;
        end
      end
    endcase
  end

  always_comb begin
    ma[0] = a3_q[0]; mu[0] = uv3_q[0];
    ma[1] = a3_q[0]; mu[1] = uv3_q[1];
    ma[2] = a3_q[0]; mu[2] = uv3_q[2];
    ma[3] = a3_q[2]; mu[3] = uv3_q[2];
    ma[4] = a3_q[3]; mu[4] = uv3_q[1];
    ma[5] = a3_q[3]; mu[5] = uv3_q[0];
    ma[6] = a3_q[1]; mu[6] = uv3_q[2];
    ma[7] = a3_q[1]; mu[7] = uv3_q[1];
    ma[8] = a3_q[2]; mu[8] = uv3_q[0];
    for (int j = 0; j < 9; j++) begin
      hi4_d[j] = (W + HW)'(ma[j]) * (W + HW)'($signed(mu[j][UW-1:LW]));
      lo4_d[j] = (W + LW + 1)'(ma[j]) * (W + LW + 1)'($signed({1'b0, mu[j][LW-1:0]}));
    end
  end

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      m5_d[j] = (MW'(hi4_q[j]) <<< LW) + MW'(lo4_q[j]);
    end
  end

  always_comb begin
    x6_d[0] = XW'(m5_q[0]) + XW'(m5_q[3]) - XW'(m5_q[4]);
    x6_d[1] = XW'(m5_q[1]) + XW'(m5_q[5]) - XW'(m5_q[6]);
    x6_d[2] = XW'(m5_q[2]) + XW'(m5_q[7]) - XW'(m5_q[8]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xdbl[k] = ((XW + 2)'(x6_q[k]) <<< 1) + HALF_X;
      y7_d[k] = xdbl[k][XW+1:F];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      z8[k]   = ZW'(y7_q[k]) + ZW'(bv7_q[k]);
      zsat[k] = sat_fn(SW'(z8[k]));
    end
    if (f7_q == qalu_pkg::FUNC_ROT) begin
      r8_d[0] = '0;
      s8_d    = zsat[0][W] | zsat[1][W] | zsat[2][W];
      for (int k = 0; k < 3; k++) begin
        r8_d[k+1] = zsat[k][W-1:0];
      end
    end else begin
      r8_d = res7_q;
      s8_d = rs7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q   <= func_i;
      a1_q   <= a_i;
      for (int k = 0; k < 3; k++) begin
        bv1_q[k] <= b_i[k+1];
      end
      p1_q   <= p1_d;

      f2_q   <= f1_q;
      a2_q   <= a1_q;
      bv2_q  <= bv1_q;
      t2_q   <= t2_d;
      c2_q   <= c2_d;

      f3_q   <= f2_q;
      a3_q   <= a2_q;
      bv3_q  <= bv2_q;
      t3_q   <= t3_d;
      uv3_q  <= uv3_d;

      f4_q   <= f3_q;
      bv4_q  <= bv3_q;
      res4_q <= res4_d;
      rs4_q  <= rs4_d;
      hi4_q  <= hi4_d;
      lo4_q  <= lo4_d;

      f5_q   <= f4_q;
      bv5_q  <= bv4_q;
      res5_q <= res4_q;
      rs5_q  <= rs4_q;
      m5_q   <= m5_d;

      f6_q   <= f5_q;
      bv6_q  <= bv5_q;
      res6_q <= res5_q;
      rs6_q  <= rs5_q;
      x6_q   <= x6_d;

      f7_q   <= f6_q;
      bv7_q  <= bv6_q;
      res7_q <= res6_q;
      rs7_q  <= rs6_q;
      y7_q   <= y7_d;

      f8_q   <= f7_q;
      r8_q   <= r8_d;
      s8_q   <= s8_d;
    end
  end

  assign func_o = f8_q;
  assign r_o    = r8_q;
  assign sat_o  = s8_q;

endmodule

// ===== design/qalu_norm.sv =====
module qalu_norm #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] a_i [qalu_pkg::NUM_COMP],
  output logic signed [W-1:0] r_o [qalu_pkg::NUM_COMP],
  output logic                zero_o,
  output logic                sat_o
);

  localparam int NS  = W + 1;
  localparam int RW  = 2 * W + 2;
  localparam int RMW = W + 3;
  localparam int ND  = F + 1;
  localparam int NW  = W + F;
  localparam int DW  = W + F + 2;
  localparam int QW  = F + 1;
  localparam int NSW = (F + 3 > W + 1) ? F + 3 : W + 1;

  localparam logic signed [NSW-1:0] ONE_V = NSW'(2 ** F);

  function automatic logic [W:0] sat_fn(input logic signed [NSW-1:0] v);
    logic [NSW-W:0] hi;
    hi = v[NSW-1:W-1];
    if ((&hi) || !(|hi)) begin
      sat_fn = {1'b0, v[W-1:0]};
    end else begin
      sat_fn = {1'b1, v[NSW-1], {(W-1){~v[NSW-1]}}};
    end
  endfunction

  logic [W-1:0]     mag0 [4];
  logic [2*W-1:0]   sq1_q [4];
  logic [W-1:0]     mag1_q [4];
  logic             neg1_q [4];
  logic             zero1_q;
  logic [RW-1:0]    s2_q;
  logic [W-1:0]     mag2_q [4];
  logic             neg2_q [4];
  logic             zero2_q;

  logic [RW-1:0]    rad_in, rad_d [NS], rad_q [NS];
  logic [RMW-1:0]   rem_in, rem_d [NS], rem_q [NS];
  logic [W:0]       root_in, root_d [NS], root_q [NS];
  logic [RMW+1:0]   cur;
  logic [RMW+2:0]   trial;
  logic [W-1:0]     smag_q [NS][4];
  logic             sneg_q [NS][4];
  logic             szero_q [NS];

  logic [NW-1:0]    rr_in, dr_d [ND][4], dr_q [ND][4];
  logic [QW-1:0]    q_in, dq_d [ND][4], dq_q [ND][4];
  logic [W:0]       len_in;
  logic [DW-1:0]    diff;
  logic [W:0]       dlen_q [ND];
  logic             dneg_q [ND][4];
  logic             dzero_q [ND];

  logic [QW:0]      rq_d [4], rq_q [4];
  logic             rneg_q [4];
  logic             rzero_q;

  logic [NSW-1:0]   qext [4];
  logic signed [NSW-1:0] sv [4];
  logic [W:0]       vsat [4];
  logic [W:0]       osat;
  logic signed [W-1:0] r_d [4], r_q [4];
  logic             sat_d, sat_q, zero_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag0[i] = a_i[i][W-1] ? W'(-a_i[i]) : W'(a_i[i]);
    end
  end

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rad_in  = s2_q;
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_q[s-1];
        rem_in  = rem_q[s-1];
        root_in = root_q[s-1];
      end
      cur   = {rem_in, rad_in[RW-1:RW-2]};
      trial = (RMW + 3)'(cur) - (RMW + 3)'({root_in, 2'b01});
      if (!trial[RMW+2]) begin
        rem_d[s]  = trial[RMW-1:0];
        root_d[s] = {root_in[W-1:0], 1'b1};
      end else begin
        rem_d[s]  = cur[RMW-1:0];
        root_d[s] = {root_in[W-1:0], 1'b0};
      end
      rad_d[s] = rad_in << 2;
    end
  end

  always_comb begin
    for (int j = 0; j < ND; j++) begin
      for (int i = 0; i < 4; i++) begin
        if (j == 0) begin
          rr_in  = {smag_q[NS-1][i], {F{1'b0}}};
          q_in   = '0;
          len_in = root_q[NS-1];
        end else begin
          rr_in  = dr_q[j-1][i];
          q_in   = dq_q[j-1][i];
          len_in = dlen_q[j-1];
        end
        diff = DW'(rr_in) - (DW'(len_in) << (F - j));
        if (!diff[DW-1]) begin
          dr_d[j][i] = diff[NW-1:0];
          dq_d[j][i] = {q_in[QW-2:0], 1'b1};
        end else begin
          dr_d[j][i] = rr_in;
          dq_d[j][i] = {q_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rq_d[i] = (QW + 1)'(dq_q[ND-1][i])
              + (QW + 1)'((NW + 1)'({dr_q[ND-1][i], 1'b0}) >= (NW + 1)'(dlen_q[ND-1]));
    end
  end

  always_comb begin
    sat_d = 1'b0;
    osat  = sat_fn(ONE_V);
    for (int i = 0; i < 4; i++) begin
      qext[i] = NSW'(rq_q[i]);
      sv[i]   = rneg_q[i] ? -$signed(qext[i]) : $signed(qext[i]);
      vsat[i] = sat_fn(sv[i]);
    end
    if (rzero_q) begin
      r_d[0] = osat[W-1:0];
      sat_d  = osat[W];
      for (int i = 1; i < 4; i++) begin
        r_d[i] = '0;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        r_d[i] = vsat[i][W-1:0];
        sat_d  = sat_d | vsat[i][W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        sq1_q[i]  <= (2 * W)'(mag0[i]) * (2 * W)'(mag0[i]);
        mag1_q[i] <= mag0[i];
        neg1_q[i] <= a_i[i][W-1];
      end
      zero1_q <= !(|a_i[0]) && !(|a_i[1]) && !(|a_i[2]) && !(|a_i[3]);

      s2_q    <= RW'(sq1_q[0]) + RW'(sq1_q[1]) + RW'(sq1_q[2]) + RW'(sq1_q[3]);
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;

      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      for (int s = 0; s < NS; s++) begin
        if (s == 0) begin
          smag_q[s]  <= mag2_q;
          sneg_q[s]  <= neg2_q;
          szero_q[s] <= zero2_q;
        end else begin
          smag_q[s]  <= smag_q[s-1];
          sneg_q[s]  <= sneg_q[s-1];
          szero_q[s] <= szero_q[s-1];
        end
      end

      dr_q <= dr_d;
      dq_q <= dq_d;
      for (int j = 0; j < ND; j++) begin
        if (j == 0) begin
          dlen_q[j]  <= root_q[NS-1];
          dneg_q[j]  <= sneg_q[NS-1];
          dzero_q[j] <= szero_q[NS-1];
        end else begin
          dlen_q[j]  <= dlen_q[j-1];
          dneg_q[j]  <= dneg_q[j-1];
          dzero_q[j] <= dzero_q[j-1];
        end
      end

      rq_q    <= rq_d;
      rneg_q  <= dneg_q[ND-1];
      rzero_q <= dzero_q[ND-1];

      r_q    <= r_d;
      sat_q  <= sat_d;
      zero_q <= rzero_q;
    end
  end

  assign r_o    = r_q;
  assign zero_o = zero_q;
  assign sat_o  = sat_q;

endmodule

// ===== design/quaternion_alu.sv =====
// channel  valid        stall         word
// in       in_valid_i   in_stall_o    func_i, a_w_i..a_z_i, b_w_i..b_z_i
// out      out_valid_o  out_stall_i   r_w_o..r_z_o, zero_length_o, saturated_o
//
// One word enters per cycle while the output is not stalled.
// The latency is set by the normalize path: square root one root bit per stage,
// then the divider one quotient bit per stage; other functions are delayed to match.
// Reset clears only the valid bits of the stages.
// A stalled output word freezes the whole pipeline and raises in_stall_o.
module quaternion_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  qalu_pkg::func_t             func_i,
  input  logic signed [WORD_BITS-1:0] a_w_i,
  input  logic signed [WORD_BITS-1:0] a_x_i,
  input  logic signed [WORD_BITS-1:0] a_y_i,
  input  logic signed [WORD_BITS-1:0] a_z_i,
  input  logic signed [WORD_BITS-1:0] b_w_i,
  input  logic signed [WORD_BITS-1:0] b_x_i,
  input  logic signed [WORD_BITS-1:0] b_y_i,
  input  logic signed [WORD_BITS-1:0] b_z_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] r_w_o,
  output logic signed [WORD_BITS-1:0] r_x_o,
  output logic signed [WORD_BITS-1:0] r_y_o,
  output logic signed [WORD_BITS-1:0] r_z_o,
  output logic                        zero_length_o,
  output logic                        saturated_o
);

  localparam int W     = WORD_BITS;
  localparam int LAT_N = WORD_BITS + FRAC_BITS + 6;
  localparam int DLY   = LAT_N - qalu_pkg::ARITH_LAT;
  localparam int LAT   = LAT_N + 1;

  logic                en;
  logic [LAT-1:0]      vld_q;

  logic signed [W-1:0] a_in [qalu_pkg::NUM_COMP];
  logic signed [W-1:0] b_in [qalu_pkg::NUM_COMP];

  qalu_pkg::func_t     ar_func;
  logic signed [W-1:0] ar_r [qalu_pkg::NUM_COMP];
  logic                ar_sat;

  logic signed [W-1:0] nm_r [qalu_pkg::NUM_COMP];
  logic                nm_zero;
  logic                nm_sat;

  qalu_pkg::func_t     dly_f_q [DLY];
  logic signed [W-1:0] dly_r_q [DLY][qalu_pkg::NUM_COMP];
  logic                dly_s_q [DLY];

  logic signed [W-1:0] out_r_d [qalu_pkg::NUM_COMP];
  logic signed [W-1:0] out_r_q [qalu_pkg::NUM_COMP];
  logic                out_z_d, out_z_q, out_s_d, out_s_q;

  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = vld_q[LAT-1] && out_stall_i;

  assign a_in[0] = a_w_i;
  assign a_in[1] = a_x_i;
  assign a_in[2] = a_y_i;
  assign a_in[3] = a_z_i;
  assign b_in[0] = b_w_i;
  assign b_in[1] = b_x_i;
  assign b_in[2] = b_y_i;
  assign b_in[3] = b_z_i;

  qalu_arith #(
    .W (WORD_BITS),
    .F (FRAC_BITS)
  ) u_arith (
    .clk_i  (clk_i),
    .en_i   (en),
    .func_i (func_i),
    .a_i    (a_in),
    .b_i    (b_in),
    .func_o (ar_func),
    .r_o    (ar_r),
    .sat_o  (ar_sat)
  );

  qalu_norm #(
    .W (WORD_BITS),
    .F (FRAC_BITS)
  ) u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a_in),
    .r_o    (nm_r),
    .zero_o (nm_zero),
    .sat_o  (nm_sat)
  );

  always_comb begin
    if (dly_f_q[DLY-1] == qalu_pkg::FUNC_NORM) begin
      out_r_d = nm_r;
      out_z_d = nm_zero;
      out_s_d = nm_sat;
    end else begin
      out_r_d = dly_r_q[DLY-1];
      out_z_d = 1'b0;
      out_s_d = dly_s_q[DLY-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < DLY; i++) begin
        if (i == 0) begin
          dly_f_q[i] <= ar_func;
          dly_r_q[i] <= ar_r;
          dly_s_q[i] <= ar_sat;
        end else begin
          dly_f_q[i] <= dly_f_q[i-1];
          dly_r_q[i] <= dly_r_q[i-1];
          dly_s_q[i] <= dly_s_q[i-1];
        end
      end
      out_r_q <= out_r_d;
      out_z_q <= out_z_d;
      out_s_q <= out_s_d;
    end
  end

  assign out_valid_o   = vld_q[LAT-1];
  assign r_w_o         = out_r_q[0];
  assign r_x_o         = out_r_q[1];
  assign r_y_o         = out_r_q[2];
  assign r_z_o         = out_r_q[3];
  assign zero_length_o = out_z_q;
  assign saturated_o   = out_s_q;

endmodule
